/* design/assert_macros.svh */
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off during reset
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// implication checked on the next clock
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* design/frt_pkg.sv */
// package: types and constants of the fragment reassembly tracker
`timescale 1ns / 1ps
package frt_pkg;
	localparam int CONTEXTS = 16;
	localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int MAX_FRAGS = 64;
	localparam int MAX_FRAG_BYTES = 1024;
	localparam int BYTES_MAX = 17'h1FFFF;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_COMPLETED = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_RANGE     = 3'd3,
		ST_FULL      = 3'd4,
		ST_TIMEOUT   = 3'd5,
		ST_NOT_FOUND = 3'd6,
		ST_DISABLED  = 3'd7
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] first_seq;
		logic [31:0] frag_number;
		logic [6:0]  frag_count;
		logic [10:0] frag_bytes;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] packet_begin;
		logic [16:0] total_bytes;
		logic [6:0]  fragments_seen;
	} out_beat_t;

	// front-to-back work item
	typedef struct packed {
		logic             disabled;
		logic             mode;
		logic [31:0]      first_seq;
		logic [31:0]      frag_number;
		logic [6:0]       frag_count;
		logic [10:0]      frag_bytes;
	} work_t;
endpackage

/* design/frt_front.sv */
// front end: accepts beats, clamps bytes, tags disabled beats, fills the queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  frt_pkg::in_beat_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output frt_pkg::work_t    q_data
);
	logic                 enable_q;
	frt_pkg::work_t       mem_q [frt_pkg::QUEUE_DEPTH];
	frt_pkg::qptr_t       wptr_q, rptr_q;
	frt_pkg::qcnt_t       cnt_q;
	logic                 push, pop;
	frt_pkg::work_t       w;

	assign cfg_ready = 1'b1;
	assign in_ready  = (cnt_q != frt_pkg::qcnt_t'(frt_pkg::QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_data    = mem_q[rptr_q];

	always_comb begin
		w.disabled     = !enable_q;
		w.mode         = in_data.mode;
		w.first_seq    = in_data.first_seq;
		w.frag_number  = in_data.frag_number;
		w.frag_count   = in_data.frag_count;
		w.frag_bytes   = (in_data.frag_bytes > 11'(frt_pkg::MAX_FRAG_BYTES)) ?
			11'(frt_pkg::MAX_FRAG_BYTES) : in_data.frag_bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			wptr_q   <= '0;
			rptr_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) enable_q <= cfg_data;
			if (push) wptr_q <= (wptr_q == frt_pkg::qptr_t'(frt_pkg::QUEUE_DEPTH - 1)) ?
				'0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == frt_pkg::qptr_t'(frt_pkg::QUEUE_DEPTH - 1)) ?
				'0 : rptr_q + 1'b1;
			cnt_q <= cnt_q + frt_pkg::qcnt_t'(push) - frt_pkg::qcnt_t'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= w;
	end

	`ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= frt_pkg::qcnt_t'(frt_pkg::QUEUE_DEPTH))
	`ASSERT_NXT(a_push_counts, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`ASSERT_NXT(a_pop_counts, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
endmodule

/* design/frt_back.sv */
// back end: context table lookup and read-modify-write, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  frt_pkg::work_t      q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output frt_pkg::out_beat_t  out_data
);
	localparam int N = frt_pkg::CONTEXTS;
	localparam int W = frt_pkg::CTX_W;

	logic        valid_q    [N];
	logic [31:0] begin_q    [N];
	logic [6:0]  count_q    [N];
	logic [6:0]  recv_q     [N];
	logic [63:0] bitmap_q   [N];
	logic [16:0] bytes_q    [N];

	// stage 1: match vectors registered
	logic           busy_s1;
	frt_pkg::work_t w_s1;
	logic           key_hit_s1, cov_hit_s1, free_hit_s1;
	logic [W-1:0]   key_idx_s1, cov_idx_s1, free_idx_s1;

	logic           key_hit, cov_hit, free_hit;
	logic [W-1:0]   key_idx, cov_idx, free_idx;
	logic           take, out_free;

	assign out_free = !out_valid || out_ready;
	assign q_ready  = !busy_s1;
	assign take     = q_valid && q_ready;

	always_comb begin
		key_hit = 1'b0; cov_hit = 1'b0; free_hit = 1'b0;
		key_idx = '0; cov_idx = '0; free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (valid_q[i] && begin_q[i] == q_data.first_seq) begin
				key_hit = 1'b1; key_idx = W'(i);
			end
			if (valid_q[i] && (q_data.frag_number - begin_q[i]) < 32'(count_q[i])) begin
				cov_hit = 1'b1; cov_idx = W'(i);
			end
			if (!valid_q[i]) begin
				free_hit = 1'b1; free_idx = W'(i);
			end
		end
	end

	// stage 2 decision
	logic [31:0]          off;
	logic [63:0]          bit_m;
	logic [17:0]          sum;
	logic [16:0]          sum_sat;
	logic [6:0]           rnew;
	frt_pkg::out_beat_t   res;
	logic                 wr_upd, wr_open, wr_free;
	logic [W-1:0]         widx;

	always_comb begin
		off     = w_s1.frag_number - w_s1.first_seq;
		bit_m   = 64'd1 << off[5:0];
		sum     = 18'(bytes_q[key_idx_s1]) + 18'(w_s1.frag_bytes);
		sum_sat = sum[17] ? 17'(frt_pkg::BYTES_MAX) : sum[16:0];
		rnew    = recv_q[key_idx_s1] + 7'd1;
		res     = '0;
		wr_upd  = 1'b0; wr_open = 1'b0; wr_free = 1'b0;
		widx    = key_idx_s1;
		res.packet_begin = w_s1.first_seq;
		priority if (w_s1.disabled) begin
			res.status = frt_pkg::ST_DISABLED;
		end else if (w_s1.mode) begin
			if (!cov_hit_s1) begin
				res.status = frt_pkg::ST_NOT_FOUND;
				res.packet_begin = '0;
			end else begin
				res.status = frt_pkg::ST_TIMEOUT;
				res.packet_begin = begin_q[cov_idx_s1];
				res.fragments_seen = recv_q[cov_idx_s1];
				wr_free = 1'b1; widx = cov_idx_s1;
			end
		end else if (key_hit_s1) begin
			res.fragments_seen = recv_q[key_idx_s1];
			if (off >= 32'(count_q[key_idx_s1])) begin
				res.status = frt_pkg::ST_RANGE;
			end else if ((bitmap_q[key_idx_s1] & bit_m) != '0) begin
				res.status = frt_pkg::ST_DUPLICATE;
			end else begin
				res.fragments_seen = rnew;
				if (rnew >= count_q[key_idx_s1]) begin
					res.status = frt_pkg::ST_COMPLETED;
					res.total_bytes = sum_sat;
					wr_free = 1'b1;
				end else begin
					res.status = frt_pkg::ST_ACCEPTED;
					wr_upd = 1'b1;
				end
			end
		end else if (!free_hit_s1) begin
			res.status = frt_pkg::ST_FULL;
		end else if (w_s1.frag_count == 7'd0 || w_s1.frag_count > 7'(frt_pkg::MAX_FRAGS)
			|| off >= 32'(w_s1.frag_count)) begin
			res.status = frt_pkg::ST_RANGE;
		end else if (w_s1.frag_count == 7'd1) begin
			res.status = frt_pkg::ST_COMPLETED;
			res.total_bytes = 17'(w_s1.frag_bytes);
			res.fragments_seen = 7'd1;
		end else begin
			res.status = frt_pkg::ST_ACCEPTED;
			res.fragments_seen = 7'd1;
			wr_open = 1'b1; widx = free_idx_s1;
		end
	end

	logic fire;
	assign fire = busy_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < N; i++) valid_q[i] <= 1'b0;
		end else begin
			if (take) busy_s1 <= 1'b1;
			else if (fire) busy_s1 <= 1'b0;
			if (fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (fire && wr_free) valid_q[widx] <= 1'b0;
			if (fire && wr_open) valid_q[widx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_s1 <= q_data;
			key_hit_s1 <= key_hit; key_idx_s1 <= key_idx;
			cov_hit_s1 <= cov_hit; cov_idx_s1 <= cov_idx;
			free_hit_s1 <= free_hit; free_idx_s1 <= free_idx;
		end
		if (fire) out_data <= res;
		if (fire && wr_upd) begin
			bitmap_q[widx] <= bitmap_q[widx] | bit_m;
			recv_q[widx]   <= rnew;
			bytes_q[widx]  <= sum_sat;
		end
		if (fire && wr_open) begin
			begin_q[widx]  <= w_s1.first_seq;
			count_q[widx]  <= w_s1.frag_count;
			recv_q[widx]   <= 7'd1;
			bitmap_q[widx] <= bit_m;
			bytes_q[widx]  <= 17'(w_s1.frag_bytes);
		end
	end

	`ASSERT_IMP(a_one_write, clk, arst_n, fire, !(wr_upd && wr_open) && !(wr_free && wr_open))
	`ASSERT_NXT(a_fire_shows, clk, arst_n, fire, out_valid)
	`ASSERT_NXT(a_take_busy, clk, arst_n, take, busy_s1 && !q_ready)
endmodule

/* design/fragment_reassembly_tracker.sv */
// top level: fragment reassembly tracker
//  channel | dir | payload
//  cfg     | in  | deliver_enable bit
//  in      | in  | in_beat_t fragment or timeout beat
//  out     | out | out_beat_t one result per beat
// each beat in the back end: match against all contexts, registered, then
// one read-modify-write of the chosen context and the result register
// a two-entry queue sits between front and back; results wait in an output register
// reset clears all context valid bits and the enable bit at once
`timescale 1ns / 1ps
module fragment_reassembly_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  frt_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output frt_pkg::out_beat_t  out_data
);
	logic           q_valid, q_ready;
	frt_pkg::work_t q_data;

	frt_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.in_valid, .in_ready, .in_data, .q_valid, .q_ready, .q_data
	);

	frt_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .out_data
	);
endmodule

/* tb/tb_fragment_reassembly_tracker.sv */
// testbench: fragment reassembly tracker, self-checking with random stimulus and stalls
`timescale 1ns / 1ps
module tb_fragment_reassembly_tracker;
	import frt_pkg::*;

	class reassembly_board;
		bit        live [CONTEXTS];
		bit [31:0] key [CONTEXTS];
		bit [6:0]  count [CONTEXTS];
		bit [6:0]  got [CONTEXTS];
		bit [63:0] seen_map [CONTEXTS];
		bit [16:0] bytes [CONTEXTS];
		bit        enable;
		out_beat_t pending [$];
		int        errors;

		function void clear();
			foreach (live[i]) live[i] = 0;
			enable = 0;
			errors = 0;
		endfunction

		function void note_fragment(in_beat_t b);
			out_beat_t r;
			bit [31:0] off;
			bit [10:0] nb;
			bit [17:0] sum;
			int c;
			r = '0;
			c = -1;
			nb = (b.frag_bytes > MAX_FRAG_BYTES) ? 11'(MAX_FRAG_BYTES) : b.frag_bytes;
			off = b.frag_number - b.first_seq;
			if (!enable) begin
				r.status = ST_DISABLED;
				r.packet_begin = b.first_seq;
			end else if (b.mode) begin
				for (int i = 0; i < CONTEXTS; i++)
					if (c < 0 && live[i] && (b.frag_number - key[i]) < 32'(count[i])) c = i;
				if (c < 0) r.status = ST_NOT_FOUND;
				else begin
					r.status = ST_TIMEOUT;
					r.packet_begin = key[c];
					r.fragments_seen = got[c];
					live[c] = 0;
				end
			end else begin
				r.packet_begin = b.first_seq;
				for (int i = 0; i < CONTEXTS; i++)
					if (c < 0 && live[i] && key[i] == b.first_seq) c = i;
				if (c >= 0) begin
					r.fragments_seen = got[c];
					if (off >= 32'(count[c])) r.status = ST_RANGE;
					else if (seen_map[c][off[5:0]]) r.status = ST_DUPLICATE;
					else begin
						seen_map[c][off[5:0]] = 1;
						got[c]++;
						sum = bytes[c] + nb;
						bytes[c] = (sum > BYTES_MAX) ? 17'(BYTES_MAX) : sum[16:0];
						r.fragments_seen = got[c];
						if (got[c] >= count[c]) begin
							r.status = ST_COMPLETED;
							r.total_bytes = bytes[c];
							live[c] = 0;
						end else r.status = ST_ACCEPTED;
					end
				end else begin
					for (int i = 0; i < CONTEXTS; i++)
						if (c < 0 && !live[i]) c = i;
					if (c < 0) r.status = ST_FULL;
					else if (b.frag_count == 0 || b.frag_count > MAX_FRAGS
							|| off >= 32'(b.frag_count)) r.status = ST_RANGE;
					else if (b.frag_count == 1) begin
						r.status = ST_COMPLETED;
						r.total_bytes = 17'(nb);
						r.fragments_seen = 1;
					end else begin
						live[c] = 1;
						key[c] = b.first_seq;
						count[c] = b.frag_count;
						got[c] = 1;
						seen_map[c] = 64'd1 << off[5:0];
						bytes[c] = 17'(nb);
						r.status = ST_ACCEPTED;
						r.fragments_seen = 1;
					end
				end
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(out_beat_t a);
			out_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status);
				errors++;
			end
			if (a.packet_begin !== e.packet_begin) begin
				$error("packet_begin exp %0h got %0h", e.packet_begin, a.packet_begin);
				errors++;
			end
			if (a.total_bytes !== e.total_bytes) begin
				$error("total_bytes exp %0d got %0d", e.total_bytes, a.total_bytes);
				errors++;
			end
			if (a.fragments_seen !== e.fragments_seen) begin
				$error("fragments_seen exp %0d got %0d", e.fragments_seen, a.fragments_seen);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic      cfg_data = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_beat_t out_data;

	reassembly_board board;
	bit  hold_rx = 0;
	bit  no_gaps = 0;
	int  random_left = 975;

	fragment_reassembly_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	task automatic write_enable(bit v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.enable = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// valid stays up between beats sent with no gap
	task automatic send_fragment(in_beat_t b);
		int gap;
		gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
		if ($urandom_range(0, 1)) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data <= b;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		board.note_fragment(b);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic in_beat_t make_frag(bit m, bit [31:0] bg, bit [31:0] fn,
			bit [6:0] fc, bit [10:0] fb);
		in_beat_t b;
		b.mode = m;
		b.first_seq = bg;
		b.frag_number = fn;
		b.frag_count = fc;
		b.frag_bytes = fb;
		return b;
	endfunction

	// random packet: its fragments in shuffled order, sometimes dropped or doubled
	task automatic send_packet();
		bit [31:0] bg;
		int        n;
		int        order [$];
		in_beat_t  b;
		bg = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) order.insert(order.size(), i);
		order.shuffle();
		foreach (order[i]) begin
			if (random_left <= 0) return;
			b = make_frag(0, bg, bg + order[i], 7'(n), 11'($urandom_range(0, 2047)));
			case ($urandom_range(0, 29))
				0: b.frag_count = 7'($urandom);
				1: b.frag_number = $urandom;
				2: b.mode = 1'b1;
				3: b.frag_number = bg - 1;
				default: ;
			endcase
			if ($urandom_range(0, 15) == 0) continue;
			send_fragment(b);
			random_left--;
			if ($urandom_range(0, 19) == 0) begin
				send_fragment(b);
				random_left--;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	initial begin
		int stretch;
		forever begin
			@(negedge clk);
			if (hold_rx) out_ready <= 0;
			else if (stretch > 0) begin
				out_ready <= 0;
				stretch--;
			end else begin
				out_ready <= 1;
				if ($urandom_range(0, 3) == 0) stretch = $urandom_range(0, 19);
			end
		end
	end

	initial begin
		#50_000_000;
		$display("tb_fragment_reassembly_tracker: done, errors");
		$finish;
	end

	initial begin
		board = new();
		board.clear();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// disabled after reset
		send_fragment(make_frag(0, 32'hFFFF_FFFF, 32'h0, 7'd127, 11'h7FF));
		send_fragment(make_frag(1, 32'h0, 32'h0, 7'd0, 11'h0));
		drain();
		write_enable(1);
		// single fragment, oversize, range cases
		send_fragment(make_frag(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1, 11'h7FF));
		send_fragment(make_frag(0, 32'd10, 32'd10, 7'd0, 11'd5));
		send_fragment(make_frag(0, 32'd10, 32'd10, 7'd65, 11'd5));
		send_fragment(make_frag(0, 32'd10, 32'd9, 7'd4, 11'd5));
		// open, duplicate, out of range on context, complete
		send_fragment(make_frag(0, 32'd100, 32'd101, 7'd3, 11'd1024));
		send_fragment(make_frag(0, 32'd100, 32'd101, 7'd99, 11'd7));
		send_fragment(make_frag(0, 32'd100, 32'd103, 7'd3, 11'd7));
		send_fragment(make_frag(0, 32'd100, 32'd100, 7'd3, 11'd1025));
		send_fragment(make_frag(0, 32'd100, 32'd102, 7'd3, 11'd0));
		// 64-fragment packet at the top of the range, oversize fragments clamped
		for (int i = 0; i < 64; i++)
			send_fragment(make_frag(0, 32'hFFFF_FFE0, 32'hFFFF_FFE0 + i, 7'd64, 11'h7FF));
		// fill table, then full, timeout and not found
		for (int i = 0; i < CONTEXTS; i++)
			send_fragment(make_frag(0, 32'(1000 + 10 * i), 32'(1000 + 10 * i), 7'd5, 11'd1));
		send_fragment(make_frag(0, 32'd5000, 32'd5000, 7'd2, 11'd1));
		send_fragment(make_frag(1, 32'd0, 32'd1034, 7'd0, 11'd0));
		send_fragment(make_frag(1, 32'd0, 32'd1039, 7'd0, 11'd0));
		for (int i = 0; i < CONTEXTS; i++)
			send_fragment(make_frag(1, 32'hFFFF_FFFF, 32'(1000 + 10 * i), 7'h7F, 11'h7FF));
		drain();

		// long receiver stall while the sender keeps offering beats
		fork
			begin
				hold_rx = 1;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			begin
				no_gaps = 1;
				repeat (12) send_fragment(make_frag(1, $urandom, $urandom, 7'($urandom),
					11'($urandom)));
				no_gaps = 0;
			end
		join
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			write_enable(phase != 2);
			repeat (42) begin
				if ($urandom_range(0, 9) == 0) begin
					if (random_left > 0) begin
						send_fragment(make_frag(1'($urandom), $urandom, $urandom,
							7'($urandom), 11'($urandom)));
						random_left--;
					end
				end else send_packet();
			end
			drain();
		end
		write_enable(0);
		send_fragment(make_frag(0, 32'd7, 32'd7, 7'd1, 11'd1));
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_fragment_reassembly_tracker: done, clean");
		else
			$display("tb_fragment_reassembly_tracker: done, errors");
		$finish;
	end
endmodule
